// ----- rtl/core/jsu_pkg.sv -----
// shared types, constants and helper functions of the json string unescaper
`default_nettype none
package jsu_pkg;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);
	localparam logic [CMDQ_CW-1:0] CMDQ_FULL = CMDQ_CW'(CMDQ_DEPTH);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;

	localparam logic [5:0] SUR_HI_TAG = 6'b110110;
	localparam logic [5:0] SUR_LO_TAG = 6'b110111;
	localparam logic [1:0] HEX_CNT_LAST = 2'd3;
	localparam logic [1:0] SUR_LEN_M1 = 2'd2;

	// one decoded word list: segments go out in order a, b, c, d, e
	typedef struct packed {
		logic            a_en;
		logic [9:0]      a_sur;
		logic            b_en;
		logic [1:0]      b_cnt;
		logic [2:0][7:0] b_held;
		logic            c_en;
		logic [20:0]     c_cp;
		logic [1:0]      c_len;
		logic            d_en;
		logic [7:0]      d_byte;
		logic            e_en;
		logic            last;
	} cmd_t;

	// {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [7:0] esc_map(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			CH_N: begin
				r = 8'h0A;
			end
			CH_R: begin
				r = 8'h0D;
			end
			CH_T: begin
				r = 8'h09;
			end
			CH_B: begin
				r = 8'h08;
			end
			CH_F: begin
				r = 8'h0C;
			end
			default: begin
				r = c;
			end
		endcase
		return r;
	endfunction

	function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
		logic [1:0] r;
		priority if (cp <= 21'h7F) begin
			r = 2'd0;
		end else if (cp <= 21'h7FF) begin
			r = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
			input logic [1:0] idx);
		logic [7:0] r;
		logic [7:0] t0;
		logic [7:0] t1;
		logic [7:0] t2;
		t0 = 8'h80 | {2'b00, cp[5:0]};
		t1 = 8'h80 | {2'b00, cp[11:6]};
		t2 = 8'h80 | {2'b00, cp[17:12]};
		unique case (len_m1)
			2'd0: begin
				r = cp[7:0];
			end
			2'd1: begin
				r = (idx == 2'd0) ? (8'hC0 | {3'b000, cp[10:6]}) : t0;
			end
			2'd2: begin
				unique case (idx)
					2'd0: r = 8'hE0 | {4'b0000, cp[15:12]};
					2'd1: r = t1;
					default: r = t0;
				endcase
			end
			default: begin
				unique case (idx)
					2'd0: r = 8'hF0 | {5'b00000, cp[20:18]};
					2'd1: r = t2;
					2'd2: r = t1;
					default: r = t0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/jsu_front.sv -----
// escape decoder: takes input words, tracks escape state and classifies output segments
`default_nettype none
module jsu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	input  wire logic          accept,
	output jsu_pkg::cmd_t      cmd,
	output logic               cmd_push
);

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_ESC    = 6'b000010,
		MODE_HEX    = 6'b000100,
		MODE_SUR    = 6'b001000,
		MODE_SURESC = 6'b010000,
		MODE_SURHEX = 6'b100000
	} mode_t;

	mode_t           mode_q;
	mode_t           nxt_mode;
	logic [1:0]      cnt_q;
	logic [1:0]      nxt_cnt;
	logic [11:0]     hex_q;
	logic [11:0]     nxt_hex;
	logic [9:0]      sur_q;
	logic [9:0]      nxt_sur;
	logic [2:0][7:0] held_q;
	logic            held_we;
	logic [4:0]      dig;
	logic [15:0]     code_v;
	logic [20:0]     pair_cp;
	logic            run_idle;

	assign dig = jsu_pkg::hex_decode(in_byte);
	assign code_v = {hex_q, dig[3:0]};
	assign pair_cp = {5'({1'b0, sur_q[9:6]} + 5'd1), sur_q[5:0], code_v[9:0]};

	always_comb begin
		nxt_mode = mode_q;
		nxt_cnt = cnt_q;
		nxt_hex = hex_q;
		nxt_sur = sur_q;
		held_we = 1'b0;
		run_idle = 1'b0;
		cmd = '0;
		cmd.b_cnt = cnt_q;
		cmd.last = in_last;

		unique case (mode_q)
			MODE_ESC: begin
				nxt_mode = MODE_IDLE;
				if (in_byte == jsu_pkg::CH_U) begin
					nxt_mode = MODE_HEX;
					nxt_cnt = '0;
					nxt_hex = '0;
				end else begin
					cmd.d_en = 1'b1;
					cmd.d_byte = jsu_pkg::esc_map(in_byte);
				end
			end
			MODE_HEX: begin
				if (dig[4]) begin
					if (cnt_q == jsu_pkg::HEX_CNT_LAST) begin
						nxt_cnt = '0;
						if (code_v[15:10] == jsu_pkg::SUR_HI_TAG) begin
							nxt_sur = code_v[9:0];
							nxt_mode = MODE_SUR;
						end else begin
							cmd.c_en = 1'b1;
							cmd.c_cp = {5'd0, code_v};
							nxt_mode = MODE_IDLE;
						end
					end else begin
						held_we = 1'b1;
						nxt_cnt = cnt_q + 2'd1;
						nxt_hex = {hex_q[7:0], dig[3:0]};
					end
				end else begin
					cmd.b_en = 1'b1;
					run_idle = 1'b1;
				end
			end
			MODE_SUR: begin
				if (in_byte == jsu_pkg::CH_BSLASH) begin
					nxt_mode = MODE_SURESC;
				end else begin
					cmd.a_en = 1'b1;
					cmd.a_sur = sur_q;
					run_idle = 1'b1;
				end
			end
			MODE_SURESC: begin
				if (in_byte == jsu_pkg::CH_U) begin
					nxt_mode = MODE_SURHEX;
					nxt_cnt = '0;
					nxt_hex = '0;
				end else begin
					cmd.a_en = 1'b1;
					cmd.a_sur = sur_q;
					cmd.d_en = 1'b1;
					cmd.d_byte = jsu_pkg::esc_map(in_byte);
					nxt_mode = MODE_IDLE;
				end
			end
			MODE_SURHEX: begin
				if (dig[4]) begin
					if (cnt_q == jsu_pkg::HEX_CNT_LAST) begin
						nxt_cnt = '0;
						if (code_v[15:10] == jsu_pkg::SUR_LO_TAG) begin
							cmd.c_en = 1'b1;
							cmd.c_cp = pair_cp;
							nxt_mode = MODE_IDLE;
						end else begin
							cmd.a_en = 1'b1;
							cmd.a_sur = sur_q;
							if (code_v[15:10] == jsu_pkg::SUR_HI_TAG) begin
								nxt_sur = code_v[9:0];
								nxt_mode = MODE_SUR;
							end else begin
								cmd.c_en = 1'b1;
								cmd.c_cp = {5'd0, code_v};
								nxt_mode = MODE_IDLE;
							end
						end
					end else begin
						held_we = 1'b1;
						nxt_cnt = cnt_q + 2'd1;
						nxt_hex = {hex_q[7:0], dig[3:0]};
					end
				end else begin
					cmd.a_en = 1'b1;
					cmd.a_sur = sur_q;
					cmd.b_en = 1'b1;
					run_idle = 1'b1;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		if (run_idle) begin
			if (in_byte == jsu_pkg::CH_BSLASH) begin
				nxt_mode = MODE_ESC;
			end else begin
				nxt_mode = MODE_IDLE;
				cmd.d_en = 1'b1;
				cmd.d_byte = in_byte;
			end
		end

		// end of string flush
		if (in_last) begin
			cmd.b_cnt = nxt_cnt;
			unique case (nxt_mode)
				MODE_ESC: begin
					cmd.e_en = 1'b1;
				end
				MODE_HEX: begin
					cmd.b_en = 1'b1;
				end
				MODE_SUR: begin
					if (cmd.a_en) begin
						cmd.c_en = 1'b1;
						cmd.c_cp = {5'd0, jsu_pkg::SUR_HI_TAG, nxt_sur};
					end else begin
						cmd.a_en = 1'b1;
						cmd.a_sur = nxt_sur;
					end
				end
				MODE_SURESC: begin
					cmd.a_en = 1'b1;
					cmd.a_sur = nxt_sur;
					cmd.e_en = 1'b1;
				end
				MODE_SURHEX: begin
					cmd.a_en = 1'b1;
					cmd.a_sur = nxt_sur;
					cmd.b_en = 1'b1;
				end
				default: begin
				end
			endcase
			nxt_mode = MODE_IDLE;
			nxt_cnt = '0;
			nxt_hex = '0;
		end

		for (int i = 0; i < 3; i++) begin
			cmd.b_held[i] = (held_we && cnt_q == 2'(i)) ? in_byte : held_q[i];
		end
		cmd.c_len = jsu_pkg::utf8_len_m1(cmd.c_cp);
	end

	assign cmd_push = accept && (cmd.a_en || cmd.b_en || cmd.c_en || cmd.d_en || cmd.e_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q <= '0;
			hex_q <= '0;
			sur_q <= '0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			cnt_q <= nxt_cnt;
			hex_q <= nxt_hex;
			sur_q <= nxt_sur;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q[cnt_q] <= in_byte;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/jsu_cmd_fifo.sv -----
// short queue of segment lists between the decoder and the serializer
`default_nettype none
module jsu_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire jsu_pkg::cmd_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output jsu_pkg::cmd_t      rd_data,
	output logic               rd_valid
);

	jsu_pkg::cmd_t                  mem_q [jsu_pkg::CMDQ_DEPTH];
	logic [jsu_pkg::CMDQ_AW-1:0]    wr_ptr_q;
	logic [jsu_pkg::CMDQ_AW-1:0]    rd_ptr_q;
	logic [jsu_pkg::CMDQ_CW-1:0]    count_q;

	assign full = count_q == jsu_pkg::CMDQ_FULL;
	assign rd_valid = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + jsu_pkg::CMDQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + jsu_pkg::CMDQ_AW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10: count_q <= count_q + jsu_pkg::CMDQ_CW'(1);
				2'b01: count_q <= count_q - jsu_pkg::CMDQ_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/jsu_back.sv -----
// serializer: emits the queue head's segments, one word per cycle while popped
`default_nettype none
module jsu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jsu_pkg::cmd_t head,
	input  wire logic          head_valid,
	output logic               head_pop,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               string_end,
	output logic               empty,
	input  wire logic          pop
);

	logic [4:0] done_q;
	logic [1:0] idx_q;
	logic [4:0] en_vec;
	logic [4:0] rem;
	logic [4:0] cur;
	logic [1:0] cur_len;
	logic [7:0] cur_byte;
	logic       seg_end;
	logic       cmd_end;
	logic       advance;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       end_q;

	assign en_vec = {head.e_en, head.d_en, head.c_en, head.b_en, head.a_en};
	assign rem = en_vec & ~done_q;

	always_comb begin
		cur = '0;
		cur_len = '0;
		cur_byte = '0;
		priority if (rem[0]) begin
			cur = 5'b00001;
			cur_len = jsu_pkg::SUR_LEN_M1;
			cur_byte = jsu_pkg::utf8_byte({5'd0, jsu_pkg::SUR_HI_TAG, head.a_sur},
				jsu_pkg::SUR_LEN_M1, idx_q);
		end else if (rem[1]) begin
			cur = 5'b00010;
			cur_len = head.b_cnt;
			unique case (idx_q)
				2'd0: cur_byte = jsu_pkg::CH_U;
				2'd1: cur_byte = head.b_held[0];
				2'd2: cur_byte = head.b_held[1];
				default: cur_byte = head.b_held[2];
			endcase
		end else if (rem[2]) begin
			cur = 5'b00100;
			cur_len = head.c_len;
			cur_byte = jsu_pkg::utf8_byte(head.c_cp, head.c_len, idx_q);
		end else if (rem[3]) begin
			cur = 5'b01000;
			cur_byte = head.d_byte;
		end else begin
			cur = 5'b10000;
			cur_byte = jsu_pkg::CH_BSLASH;
		end
	end

	assign seg_end = idx_q == cur_len;
	assign cmd_end = seg_end && ((rem & ~cur) == '0);
	assign advance = head_valid && (!valid_q || pop);
	assign head_pop = advance && cmd_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				if (seg_end) begin
					idx_q <= '0;
					done_q <= cmd_end ? '0 : (done_q | cur);
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= cur_byte;
			run_last_q <= cmd_end;
			end_q <= cmd_end && head.last;
		end
	end

	assign out_byte = byte_q;
	assign run_last = run_last_q;
	assign string_end = end_q;
	assign empty = !valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/json_string_unescape.sv -----
// top level of the json string unescaper
// path: an accepted word goes through the segment queue into the serializer's output register
// throughput: one input word per cycle while the 4-entry segment queue has room;
// the serializer gives one output word per cycle while the output is popped, so an input
// that expands to n words holds the serializer until all n words are out
// reset: arst_n clears escape state, queue pointers and the output valid at once
`default_nettype none
module json_string_unescape (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       push,
	output logic            full,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            string_end,
	output logic            empty,
	input  wire logic       pop
);

	jsu_pkg::cmd_t wr_cmd;
	jsu_pkg::cmd_t head;
	logic          cmd_push;
	logic          head_valid;
	logic          head_pop;
	logic          accept;

	assign accept = push && !full;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.accept   (accept),
		.cmd      (wr_cmd),
		.cmd_push (cmd_push)
	);

	jsu_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_data  (wr_cmd),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.rd_valid (head_valid)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
`default_nettype wire
